/* rtl/ladder_button_debounce_press_classifier_unit_assert.svh */
// Assertion macros for the ladder button classifier.
`ifndef LADDER_BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define LADDER_BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

// check cons in the same cycle as ante
`define LBDPC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define LBDPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lbdpc_pkg.sv */
package lbdpc_pkg;

   localparam int LIMIT_BITS = 12;
   localparam int COUNT_BITS = 4;
   localparam int HOLD_BITS  = 12;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

   typedef enum logic [2:0] {
      PAD_UP   = 3'd0,
      PAD_DOWN = 3'd1,
      PAD_PLAY = 3'd2,
      PAD_MENU = 3'd3,
      PAD_IDLE = 3'd4
   } btn_type;

   localparam logic KIND_SHORT = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UP_LIMIT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOWN_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLAY_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MENU_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STABLE     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS = 3'd5;

   localparam logic [LIMIT_BITS-1:0] RST_UP_LIMIT   = 12'd600;
   localparam logic [LIMIT_BITS-1:0] RST_DOWN_LIMIT = 12'd1400;
   localparam logic [LIMIT_BITS-1:0] RST_PLAY_LIMIT = 12'd2400;
   localparam logic [LIMIT_BITS-1:0] RST_MENU_LIMIT = 12'd3100;
   localparam logic [COUNT_BITS-1:0] RST_STABLE     = 4'd3;
   localparam logic [HOLD_BITS-1:0]  RST_LONG_PRESS = 12'd50;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] up_limit;
      logic [LIMIT_BITS-1:0] down_limit;
      logic [LIMIT_BITS-1:0] play_limit;
      logic [LIMIT_BITS-1:0] menu_limit;
      logic [COUNT_BITS-1:0] stable_polls;
      logic [HOLD_BITS-1:0]  long_press_polls;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] button;
      logic       kind;
   } press_evt_type;

endpackage

/* rtl/lbdpc_classify.sv */
module lbdpc_classify
   import lbdpc_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic [SAMPLE_BITS-1:0] sample,
   input  cfg_type                cfg,
   output btn_type                cls
);

   localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

   logic [CMP_BITS-1:0] mv;

   assign mv = CMP_BITS'(sample);

   always_comb begin
      if (mv < CMP_BITS'(cfg.up_limit)) begin
         cls = PAD_UP;
      end else if (mv < CMP_BITS'(cfg.down_limit)) begin
         cls = PAD_DOWN;
      end else if (mv < CMP_BITS'(cfg.play_limit)) begin
         cls = PAD_PLAY;
      end else if (mv < CMP_BITS'(cfg.menu_limit)) begin
         cls = PAD_MENU;
      end else begin
         cls = PAD_IDLE;
      end
   end

endmodule

/* rtl/lbdpc_tracker.sv */
module lbdpc_tracker
   import lbdpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  btn_type       cls,
   input  cfg_type       cfg,
   output press_evt_type evt
);

   btn_type               confirmed_ff, confirmed_in;
   btn_type               candidate_ff, candidate_in;
   logic [COUNT_BITS-1:0] run_ff, run_in;
   logic [HOLD_BITS-1:0]  hold_ff, hold_in;
   logic                  long_sent_ff, long_sent_in;
   logic                  stable;

   always_comb begin
      confirmed_in = confirmed_ff;
      candidate_in = candidate_ff;
      run_in       = run_ff;
      long_sent_in = long_sent_ff;
      evt          = '{valid: 1'b0, button: 2'd0, kind: KIND_SHORT};

      hold_in = (hold_ff != HOLD_MAX) ? hold_ff + 1'b1 : hold_ff;

      if (cls == candidate_ff) begin
         if (run_ff < cfg.stable_polls) begin
            run_in = run_ff + 1'b1;
         end
      end else begin
         candidate_in = cls;
         run_in       = COUNT_BITS'(1);
      end

      stable = (run_in >= cfg.stable_polls);

      if (stable) begin
         if (cls != confirmed_ff) begin
            confirmed_in = cls;
            if (cls != PAD_IDLE) begin
               hold_in      = '0;
               long_sent_in = 1'b0;
            end else if (!long_sent_ff) begin
               evt = '{valid: 1'b1, button: confirmed_ff[1:0], kind: KIND_SHORT};
            end
         end
         if (confirmed_in != PAD_IDLE && !long_sent_in &&
             hold_in >= cfg.long_press_polls) begin
            long_sent_in = 1'b1;
            evt = '{valid: 1'b1, button: confirmed_in[1:0], kind: KIND_LONG};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         confirmed_ff <= PAD_IDLE;
         candidate_ff <= PAD_IDLE;
         run_ff       <= '0;
         hold_ff      <= '0;
         long_sent_ff <= 1'b0;
      end else if (step) begin
         confirmed_ff <= confirmed_in;
         candidate_ff <= candidate_in;
         run_ff       <= run_in;
         hold_ff      <= hold_in;
         long_sent_ff <= long_sent_in;
      end
   end

endmodule

/* rtl/ladder_button_debounce_press_classifier_unit.sv */
// Debounces a resistor-ladder button pad and classifies presses. Each word on the
// request side is one poll sample in millivolts; four ascending limits map it to
// up, down, play, menu or no button. A class must repeat for stable_polls polls
// before it is taken. Releasing a button gives a short-press word unless its long
// press already went out; holding it for long_press_polls stable polls gives one
// long-press word. One sample is taken every clock cycle while the result side is
// not stalled; a sample goes from the input register through the debounce update,
// and any result word into the result register. A stalled result side holds the
// pipeline after one more sample is buffered. The user must write registers on the
// csr port only while no sample is in flight; the block does not enforce this.
`include "ladder_button_debounce_press_classifier_unit_assert.svh"

module ladder_button_debounce_press_classifier_unit
   import lbdpc_pkg::*;
#(
   parameter  int SAMPLE_BITS = 12,
   localparam int REQ_BITS    = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [LIMIT_BITS-1:0]     csr_wdata,

   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_BITS-1:0]       req_tdata,  // sample_mv, zero pad

   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,  // button, zero pad
   output logic [0:0]                rsp_tuser   // press_kind
);

   cfg_type                cfg_ff, cfg_in;
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;
   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             out_button_ff, out_button_in;
   logic                   out_kind_ff, out_kind_in;
   logic                   advance;
   logic                   req_take;
   btn_type                cls;
   press_evt_type          evt;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_UP_LIMIT:   cfg_in.up_limit         = csr_wdata;
            CSR_DOWN_LIMIT: cfg_in.down_limit       = csr_wdata;
            CSR_PLAY_LIMIT: cfg_in.play_limit       = csr_wdata;
            CSR_MENU_LIMIT: cfg_in.menu_limit       = csr_wdata;
            CSR_STABLE:     cfg_in.stable_polls     = csr_wdata[COUNT_BITS-1:0];
            CSR_LONG_PRESS: cfg_in.long_press_polls = csr_wdata[HOLD_BITS-1:0];
            default:        cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{up_limit: RST_UP_LIMIT, down_limit: RST_DOWN_LIMIT,
                     play_limit: RST_PLAY_LIMIT, menu_limit: RST_MENU_LIMIT,
                     stable_polls: RST_STABLE, long_press_polls: RST_LONG_PRESS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_tdata[SAMPLE_BITS-1:0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   lbdpc_classify #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_classify (
      .sample(in_sample_ff),
      .cfg   (cfg_ff),
      .cls   (cls)
   );

   lbdpc_tracker u_tracker (
      .clock(clock),
      .reset(reset),
      .step (advance),
      .cls  (cls),
      .cfg  (cfg_ff),
      .evt  (evt)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_button_in = out_button_ff;
      out_kind_in   = out_kind_ff;
      if (!out_valid_ff || rsp_tready) begin
         out_valid_in  = advance && evt.valid;
         out_button_in = evt.button;
         out_kind_in   = evt.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_sample_ff  <= in_sample_in;
      out_button_ff <= out_button_in;
      out_kind_ff   <= out_kind_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_button_ff};
   assign rsp_tuser  = out_kind_ff;

   `LBDPC_ASSERT_SAME(a_no_advance_on_stall, out_valid_ff && !rsp_tready, !advance,
      "sample advanced into a stalled result register")
   `LBDPC_ASSERT_SAME(a_full_input_blocks, in_valid_ff && !advance, !req_tready,
      "request accepted while the input register was held")
   `LBDPC_ASSERT_NEXT(a_event_lands, advance && evt.valid, out_valid_ff,
      "press event was not loaded into the result register")

endmodule
